>>> sv/jurb_pkg.sv
// Shared types and constants for the serial port register block.
`timescale 1ns / 1ps
`default_nettype none
package jurb_pkg;

	localparam int FIFO_DEPTH = 64;

	localparam logic [1:0] OP_READ    = 2'd0;
	localparam logic [1:0] OP_WRITE   = 2'd1;
	localparam logic [1:0] OP_RECEIVE = 2'd2;

	localparam logic [2:0] ADDR_DATA = 3'd0;
	localparam logic [2:0] ADDR_CTRL = 3'd4;

	localparam int DATA_VALID_BIT = 15;
	localparam int AVAIL_SHIFT    = 16;
	localparam int CTRL_RE_BIT    = 0;
	localparam int CTRL_WE_BIT    = 1;
	localparam int CTRL_RI_BIT    = 8;
	localparam int CTRL_WI_BIT    = 9;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RD_WAIT
	} ctl_state_t;

	typedef struct packed {
		logic exec;
		logic load_now;
		logic load_pop;
	} ctl_cmd_t;

	typedef struct packed {
		logic pop_needed;
	} dp_sts_t;

endpackage
`default_nettype wire

>>> sv/jurb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module jurb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = jurb_pkg::FIFO_DEPTH
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/jurb_datapath.sv
// Datapath: receive FIFO, flags, enables and result registers.
`timescale 1ns / 1ps
`default_nettype none
module jurb_datapath #(
	parameter int FIFO_DEPTH = jurb_pkg::FIFO_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire jurb_pkg::ctl_cmd_t  cmd,
	output jurb_pkg::dp_sts_t        sts,
	input  wire logic [1:0]          operation,
	input  wire logic [2:0]          address,
	input  wire logic [31:0]         write_data,
	input  wire logic [7:0]          rx_byte,
	output logic      [31:0]         read_data,
	output logic                     irq,
	output logic                     tx_valid,
	output logic      [7:0]          tx_byte,
	output logic                     rx_dropped
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             re_en_q, we_en_q, rp_q, wp_q;

	logic [PTR_W-1:0] wr_ptr_n;
	logic [CNT_W-1:0] count_n;
	logic             re_en_n, we_en_n, rp_n, wp_n;
	logic [31:0]      rdata_n;
	logic             txv_n, drop_n;
	logic [7:0]       txb_n;
	logic             full, ram_we, ram_re;
	logic [PTR_W-1:0] rd_addr;
	logic [7:0]       ram_rdata;
	logic [31:0]      ctrl_val;

	assign full    = (count_q == CNT_W'(FIFO_DEPTH));
	assign rd_addr = wr_ptr_q - count_q[PTR_W-1:0];
	assign sts.pop_needed = (operation == jurb_pkg::OP_READ) &&
		(address == jurb_pkg::ADDR_DATA) && (count_q != '0);

	always_comb begin
		ctrl_val = 32'(FIFO_DEPTH) << jurb_pkg::AVAIL_SHIFT;
		ctrl_val[jurb_pkg::CTRL_WI_BIT] = wp_q;
		ctrl_val[jurb_pkg::CTRL_RI_BIT] = rp_q;
		ctrl_val[jurb_pkg::CTRL_WE_BIT] = we_en_q;
		ctrl_val[jurb_pkg::CTRL_RE_BIT] = re_en_q;
	end

	always_comb begin
		wr_ptr_n = wr_ptr_q;
		count_n  = count_q;
		re_en_n  = re_en_q;
		we_en_n  = we_en_q;
		rp_n     = rp_q;
		wp_n     = wp_q;
		rdata_n  = '0;
		txv_n    = 1'b0;
		txb_n    = '0;
		drop_n   = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		unique case (operation)
			jurb_pkg::OP_READ: begin
				if (address == jurb_pkg::ADDR_DATA) begin
					if (count_q != '0) begin
						ram_re  = cmd.exec;
						count_n = count_q - 1'b1;
						rp_n    = 1'b1;
					end else begin
						rp_n = 1'b0;
					end
				end else if (address == jurb_pkg::ADDR_CTRL) begin
					rdata_n = ctrl_val;
				end
			end
			jurb_pkg::OP_WRITE: begin
				if (address == jurb_pkg::ADDR_DATA) begin
					txv_n = 1'b1;
					txb_n = write_data[7:0];
					wp_n  = 1'b1;
				end else if (address == jurb_pkg::ADDR_CTRL) begin
					re_en_n = write_data[jurb_pkg::CTRL_RE_BIT];
					we_en_n = write_data[jurb_pkg::CTRL_WE_BIT];
				end
			end
			jurb_pkg::OP_RECEIVE: begin
				if (full) begin
					drop_n = 1'b1;
				end else begin
					ram_we   = cmd.exec;
					wr_ptr_n = wr_ptr_q + 1'b1;
					count_n  = count_q + 1'b1;
				end
				rp_n = 1'b1;
			end
			default: begin
			end
		endcase
	end

	jurb_ram #(
		.WIDTH(8),
		.DEPTH(FIFO_DEPTH)
	) u_rx_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_ptr_q),
		.wdata(rx_byte),
		.re   (ram_re),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			count_q  <= '0;
			re_en_q  <= 1'b0;
			we_en_q  <= 1'b0;
			rp_q     <= 1'b0;
			wp_q     <= 1'b0;
		end else if (cmd.exec) begin
			wr_ptr_q <= wr_ptr_n;
			count_q  <= count_n;
			re_en_q  <= re_en_n;
			we_en_q  <= we_en_n;
			rp_q     <= rp_n;
			wp_q     <= wp_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_now) begin
			read_data  <= rdata_n;
			irq        <= (we_en_n && wp_n) || (re_en_n && rp_n);
			tx_valid   <= txv_n;
			tx_byte    <= txb_n;
			rx_dropped <= drop_n;
		end else if (cmd.load_pop) begin
			read_data <= {16'(count_q), 8'h80, ram_rdata};
			irq        <= (we_en_q && wp_q) || (re_en_q && rp_q);
			tx_valid   <= 1'b0;
			tx_byte    <= '0;
			rx_dropped <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("receive count above depth");
	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && sts.pop_needed |=> count_q == $past(count_q) - 1'b1)
		else $error("pop did not decrement count");
	a_pop_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_pop |-> rp_q)
		else $error("read pending clear after pop");
`endif

endmodule
`default_nettype wire

>>> sv/jurb_controller.sv
// Controller: request handshake, read-wait sequencing and result valid.
`timescale 1ns / 1ps
`default_nettype none
module jurb_controller (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  wire logic               out_stall,
	input  wire jurb_pkg::dp_sts_t  sts,
	output jurb_pkg::ctl_cmd_t      cmd
);

	jurb_pkg::ctl_state_t state_q, state_n;
	logic out_valid_q;
	logic accept;

	assign in_stall  = (state_q != jurb_pkg::ST_IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			jurb_pkg::ST_IDLE: begin
				if (accept && sts.pop_needed) begin
					state_n = jurb_pkg::ST_RD_WAIT;
				end
			end
			jurb_pkg::ST_RD_WAIT: begin
				state_n = jurb_pkg::ST_IDLE;
			end
			default: begin
				state_n = jurb_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.exec     = accept;
		cmd.load_now = accept && !sts.pop_needed;
		cmd.load_pop = (state_q == jurb_pkg::ST_RD_WAIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jurb_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_now || cmd.load_pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_wait_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == jurb_pkg::ST_RD_WAIT |-> !out_valid_q)
		else $error("result register busy during read wait");
	a_pop_wait: assert property (@(posedge clk) disable iff (!arst_n)
		accept && sts.pop_needed |=> state_q == jurb_pkg::ST_RD_WAIT)
		else $error("pop did not enter read wait");
	a_pop_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_pop |=> out_valid_q)
		else $error("pop result not presented");
`endif

endmodule
`default_nettype wire

>>> sv/jtag_uart_register_block_unit.sv
// Top level of the two-register serial port with receive FIFO.
`timescale 1ns / 1ps
`default_nettype none
// One request at a time: a bus read, a bus write or a received byte. The
// result is presented in the cycle after the request is taken; a data-register
// read of a non-empty FIFO passes the read-wait state, as the receive RAM
// has a registered read port. A new request is taken in the cycle the
// pending result is taken, so the sustained rate is one request per cycle
// while out_stall is low, none while a popping read waits. The RAM holds
// FIFO_DEPTH bytes (a power of two) and needs no clearing after reset.
module jtag_uart_register_block_unit #(
	parameter int FIFO_DEPTH = jurb_pkg::FIFO_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [2:0]  address,
	input  wire logic [31:0] write_data,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [31:0] read_data,
	output logic             irq,
	output logic             tx_valid,
	output logic      [7:0]  tx_byte,
	output logic             rx_dropped
);

	jurb_pkg::ctl_cmd_t cmd;
	jurb_pkg::dp_sts_t  sts;

	jurb_controller u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	jurb_datapath #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.operation (operation),
		.address   (address),
		.write_data(write_data),
		.rx_byte   (rx_byte),
		.read_data (read_data),
		.irq       (irq),
		.tx_valid  (tx_valid),
		.tx_byte   (tx_byte),
		.rx_dropped(rx_dropped)
	);

endmodule
`default_nettype wire
